FILE: sv/bri_pkg.sv
// ----------------------------------------------------------------------------
// bri_pkg
// Shared widths and constants for the bilinear RGBA interpolator.
// ----------------------------------------------------------------------------
package bri_pkg;

	// packed pixel layout
	localparam int PIX_W    = 32;
	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int NUM_TAP  = 4;

	// offset port width, 256 means 1.0 at the default fraction
	localparam int FRAC_W = 9;

	// default number of fraction bits in the offsets
	localparam int FRAC_BITS_DEF = 8;

	// tap order in the weight and pixel arrays
	localparam int TAP_TL = 0;
	localparam int TAP_TR = 1;
	localparam int TAP_BL = 2;
	localparam int TAP_BR = 3;

	typedef logic [PIX_W-1:0]  pixel_t;
	typedef logic [CHAN_W-1:0] chan_t;

endpackage

FILE: sv/bilinear_rgba_interpolator_core.sv
// ----------------------------------------------------------------------------
// bilinear_rgba_interpolator_core
// Blends four neighboring RGBA8888 pixels with bilinear weights from the
// fractional offsets and returns one packed pixel, channels truncated.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, pixel_*, frac_x/y     | request in
//  out     | out_valid, out_ready, pixel_out           | request out
//
//  Four register stages; one request per cycle is sustained while
//  out_ready holds. Stages: offset clamp, weight products, channel
//  products, channel sum and repack; out_valid rises once a request has
//  passed through all four. Each stage advances when its successor has
//  room, so bubbles close up under a stall and nothing is lost or
//  repeated. Reset clears only the stage valid bits.
//
module bilinear_rgba_interpolator_core #(
	parameter int FRAC_BITS = bri_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bri_pkg::pixel_t            pixel_top_left,
	input  bri_pkg::pixel_t            pixel_top_right,
	input  bri_pkg::pixel_t            pixel_bottom_left,
	input  bri_pkg::pixel_t            pixel_bottom_right,
	input  logic [bri_pkg::FRAC_W-1:0] frac_x,
	input  logic [bri_pkg::FRAC_W-1:0] frac_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bri_pkg::pixel_t            pixel_out
);
	import bri_pkg::*;

	// compare width for the clamp, offset width after it
	localparam int CW    = (FRAC_BITS + 1 > FRAC_W) ? FRAC_BITS + 1 : FRAC_W;
	localparam int OFS_W = FRAC_BITS + 1;
	// weight width holds ONE*ONE
	localparam int WGT_W = 2 * FRAC_BITS + 1;
	localparam int PRD_W = WGT_W + CHAN_W;
	localparam int SUM_W = PRD_W + 2;

	localparam logic [CW-1:0]    ONE_C  = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [OFS_W-1:0] ONE_O  = {{(OFS_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [SUM_W-1:0] ONE_SQ = {{(SUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: clamp offsets to one and form the complements
	logic [CW-1:0]    fx_ext, fy_ext;
	logic [OFS_W-1:0] fx_c, fy_c;
	logic [OFS_W-1:0] fx_s1, fy_s1, gx_s1, gy_s1;
	pixel_t           pix_s1 [NUM_TAP];

	assign fx_ext = CW'(frac_x);
	assign fy_ext = CW'(frac_y);
	assign fx_c   = (fx_ext > ONE_C) ? ONE_O : fx_ext[OFS_W-1:0];
	assign fy_c   = (fy_ext > ONE_C) ? ONE_O : fy_ext[OFS_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			fx_s1          <= fx_c;
			fy_s1          <= fy_c;
			gx_s1          <= ONE_O - fx_c;
			gy_s1          <= ONE_O - fy_c;
			pix_s1[TAP_TL] <= pixel_top_left;
			pix_s1[TAP_TR] <= pixel_top_right;
			pix_s1[TAP_BL] <= pixel_bottom_left;
			pix_s1[TAP_BR] <= pixel_bottom_right;
		end
	end

	// stage 2: the four bilinear weights
	logic [2*OFS_W-1:0] wp [NUM_TAP];
	logic [WGT_W-1:0]   w_s2 [NUM_TAP];
	pixel_t             pix_s2 [NUM_TAP];

	assign wp[TAP_TL] = gx_s1 * gy_s1;
	assign wp[TAP_TR] = fx_s1 * gy_s1;
	assign wp[TAP_BL] = gx_s1 * fy_s1;
	assign wp[TAP_BR] = fx_s1 * fy_s1;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			for (int k = 0; k < NUM_TAP; k++) begin
				w_s2[k]   <= wp[k][WGT_W-1:0];
				pix_s2[k] <= pix_s1[k];
			end
		end
	end

	// stage 3: weight every channel of every tap
	logic [PRD_W-1:0] prd_s3 [NUM_CHAN][NUM_TAP];

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				for (int k = 0; k < NUM_TAP; k++) begin
					prd_s3[c][k] <= PRD_W'(pix_s2[k][c*CHAN_W +: CHAN_W]) * PRD_W'(w_s2[k]);
				end
			end
		end
	end

	// stage 4: channel sums, truncate the fraction and repack
	logic [SUM_W-1:0] sum_c [NUM_CHAN];
	pixel_t           pix_sum;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			sum_c[c] = SUM_W'(prd_s3[c][TAP_TL]) + SUM_W'(prd_s3[c][TAP_TR])
				+ SUM_W'(prd_s3[c][TAP_BL]) + SUM_W'(prd_s3[c][TAP_BR]);
			pix_sum[c*CHAN_W +: CHAN_W] = sum_c[c][2*FRAC_BITS +: CHAN_W];
		end
	end

	pixel_t pix_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			pix_s4 <= pix_sum;
		end
	end

	assign out_valid = v_s4;
	assign pixel_out = pix_s4;

`ifndef SYNTHESIS
	// clamped offset and its complement make one
	a_cmpl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ((SUM_W'(fx_s1) + SUM_W'(gx_s1)) == SUM_W'(ONE_O)
			&& (SUM_W'(fy_s1) + SUM_W'(gy_s1)) == SUM_W'(ONE_O)))
		else $error("offset complement mismatch");

	// weights always sum to one squared
	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (SUM_W'(w_s2[TAP_TL]) + SUM_W'(w_s2[TAP_TR])
			+ SUM_W'(w_s2[TAP_BL]) + SUM_W'(w_s2[TAP_BR])) == ONE_SQ)
		else $error("bilinear weights do not sum to one");

	// a channel sum never overflows the eight result bits
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sum_c[0] >> (2 * FRAC_BITS + CHAN_W)) == '0
			&& (sum_c[1] >> (2 * FRAC_BITS + CHAN_W)) == '0
			&& (sum_c[2] >> (2 * FRAC_BITS + CHAN_W)) == '0
			&& (sum_c[3] >> (2 * FRAC_BITS + CHAN_W)) == '0)
		else $error("channel sum out of range");

	// an item moving out of stage two lands in stage three
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && en_s3) |=> v_s3)
		else $error("item lost between stages");

	// a stalled stage keeps its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en_s4) |=> v_s3 && v_s4)
		else $error("stalled item dropped");
`endif

endmodule

FILE: verif/bilinear_rgba_interpolator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_rgba_interpolator_core_tb
// Drives four packed RGBA taps and two offsets per request. Each accepted
// request is blended by a local model and queued. Every returned pixel is
// compared in order against that queue, with random idling on both channels.
// ----------------------------------------------------------------------------
module bilinear_rgba_interpolator_core_tb;

	import bri_pkg::*;

	localparam longint unsigned ONE_FIX  = 64'd1 << FRAC_BITS_DEF;
	localparam int              TAIL_CYC = 20;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request in
	logic              in_valid           = 1'b0;
	logic              in_ready;
	pixel_t            pixel_top_left     = '0;
	pixel_t            pixel_top_right    = '0;
	pixel_t            pixel_bottom_left  = '0;
	pixel_t            pixel_bottom_right = '0;
	logic [FRAC_W-1:0] frac_x             = '0;
	logic [FRAC_W-1:0] frac_y             = '0;

	// request out
	logic   out_valid;
	logic   out_ready = 1'b0;
	pixel_t pixel_out;

	// blended pixels still owed by the block, oldest first
	pixel_t expected_pixels [$];
	int     error_count   = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;

	bilinear_rgba_interpolator_core #(
		.FRAC_BITS(FRAC_BITS_DEF)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pixel_top_left    (pixel_top_left),
		.pixel_top_right   (pixel_top_right),
		.pixel_bottom_left (pixel_bottom_left),
		.pixel_bottom_right(pixel_bottom_right),
		.frac_x            (frac_x),
		.frac_y            (frac_y),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pixel_out         (pixel_out)
	);

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	// bilinear blend of the four taps, channel sums truncated
	function automatic pixel_t blend_pixel(input pixel_t tl, input pixel_t tr,
			input pixel_t bl, input pixel_t br,
			input logic [FRAC_W-1:0] fx_raw, input logic [FRAC_W-1:0] fy_raw);
		longint unsigned fx;
		longint unsigned fy;
		longint unsigned wt [NUM_TAP];
		longint unsigned acc;
		pixel_t          taps [NUM_TAP];
		pixel_t          blended;
		// offsets above one saturate
		fx = (fx_raw > ONE_FIX) ? ONE_FIX : longint'(fx_raw);
		fy = (fy_raw > ONE_FIX) ? ONE_FIX : longint'(fy_raw);
		taps[TAP_TL] = tl;
		taps[TAP_TR] = tr;
		taps[TAP_BL] = bl;
		taps[TAP_BR] = br;
		wt[TAP_TL] = (ONE_FIX - fx) * (ONE_FIX - fy);
		wt[TAP_TR] = fx * (ONE_FIX - fy);
		wt[TAP_BL] = (ONE_FIX - fx) * fy;
		wt[TAP_BR] = fx * fy;
		blended = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			acc = 0;
			for (int k = 0; k < NUM_TAP; k++)
				acc += longint'(taps[k][c*CHAN_W +: CHAN_W]) * wt[k];
			acc = acc >> (2 * FRAC_BITS_DEF);
			blended[c*CHAN_W +: CHAN_W] = acc[CHAN_W-1:0];
		end
		return blended;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string what, input pixel_t got, input pixel_t want);
		error_count++;
		$display("[%0t] mismatch on %s: got %08h, expected %08h", $realtime, what, got, want);
	endtask

	// output side: random stall and in-order compare
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0)
				report_mismatch("unexpected pixel_out", pixel_out, '0);
			else if (pixel_out !== expected_pixels[0])
				report_mismatch("pixel_out", pixel_out, expected_pixels.pop_front());
			else
				void'(expected_pixels.pop_front());
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// send one request; called and returns on a rising edge
	task automatic send_blend_request(input pixel_t tl, input pixel_t tr,
			input pixel_t bl, input pixel_t br,
			input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid           <= 1'b1;
		pixel_top_left     <= tl;
		pixel_top_right    <= tr;
		pixel_bottom_left  <= bl;
		pixel_bottom_right <= br;
		frac_x             <= fx;
		frac_y             <= fy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_pixels.push_back(blend_pixel(tl, tr, bl, br, fx, fy));
	endtask

	// hold off the sender until every owed pixel is back
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	// each offset at zero or one selects a single tap, plus one midpoint blend
	task automatic test_corner_taps();
		send_blend_request('0, '0, '0, '0, 9'd0, 9'd0);
		send_blend_request('1, '1, '1, '1, 9'd256, 9'd256);
		send_blend_request(32'h11223344, 32'h55667788, 32'h99aabbcc, 32'hddeeff00, 9'd0, 9'd0);
		send_blend_request(32'h11223344, 32'h55667788, 32'h99aabbcc, 32'hddeeff00, 9'd256, 9'd0);
		send_blend_request(32'h11223344, 32'h55667788, 32'h99aabbcc, 32'hddeeff00, 9'd0, 9'd256);
		send_blend_request(32'h11223344, 32'h55667788, 32'h99aabbcc, 32'hddeeff00,
			9'd256, 9'd256);
		send_blend_request(32'hff00ff00, 32'h00ff00ff, 32'h00ff00ff, 32'hff00ff00,
			9'd128, 9'd128);
	endtask

	// offsets past one clamp to one
	task automatic test_offset_saturation();
		send_blend_request(32'h01020304, 32'hf0e0d0c0, 32'h80808080, 32'h7f7f7f7f, 9'd257, 9'd0);
		send_blend_request(32'h01020304, 32'hf0e0d0c0, 32'h80808080, 32'h7f7f7f7f,
			9'd511, 9'd511);
		send_blend_request(32'h01020304, 32'hf0e0d0c0, 32'h80808080, 32'h7f7f7f7f, 9'd0, 9'd300);
		send_blend_request(32'h01020304, 32'hf0e0d0c0, 32'h80808080, 32'h7f7f7f7f,
			9'd256, 9'd384);
		send_blend_request(32'haaaaaaaa, 32'h55555555, 32'h5555aaaa, 32'haaaa5555,
			9'd255, 9'd257);
	endtask

	// truncation near the channel limits, some taps with a lone channel set
	task automatic test_channel_extremes();
		send_blend_request('1, '0, '0, '0, 9'd1, 9'd1);
		send_blend_request('0, '1, '1, '1, 9'd1, 9'd1);
		send_blend_request('1, '1, '1, '1, 9'd1, 9'd255);
		send_blend_request('1, '1, '1, '1, 9'd255, 9'd1);
		send_blend_request(32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hff000000,
			9'd170, 9'd85);
		send_blend_request(32'hff000000, 32'h00ff0000, 32'h0000ff00, 32'h000000ff,
			9'd64, 9'd192);
		send_blend_request(32'h7f80807f, 32'h807f7f80, 32'hfe0101fe, 32'h01fefe01,
			9'd129, 9'd127);
	endtask

	// random taps and offsets, mostly in range with some past one
	task automatic test_random_blends(input int count);
		pixel_t            taps [NUM_TAP];
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		int                mode;
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < NUM_TAP; k++) begin
				taps[k] = $urandom;
				// saturated channels now and then
				if ($urandom_range(9) == 0)
					for (int c = 0; c < NUM_CHAN; c++)
						taps[k][c*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hff : 8'h00;
			end
			mode = $urandom_range(99);
			if (mode < 70) begin
				fx = FRAC_W'($urandom_range(256));
				fy = FRAC_W'($urandom_range(256));
			end else if (mode < 85) begin
				fx = $urandom_range(1) ? 9'd256 : 9'd0;
				fy = $urandom_range(1) ? 9'd256 : 9'd0;
			end else begin
				fx = FRAC_W'($urandom_range(511));
				fy = FRAC_W'($urandom_range(511));
			end
			send_blend_request(taps[TAP_TL], taps[TAP_TR], taps[TAP_BL], taps[TAP_BR], fx, fy);
		end
	endtask

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 64;
		test_corner_taps();
		test_offset_saturation();
		test_channel_extremes();
		test_random_blends(230);
		drain_pipeline();

		send_idle_pct = 64;
		recv_idle_pct = 17;
		test_random_blends(230);
		drain_pipeline();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_blends(230);
		drain_pipeline();

		repeat (TAIL_CYC) @(posedge clk);
		if (error_count == 0 && expected_pixels.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
sv/bri_pkg.sv
sv/bilinear_rgba_interpolator_core.sv
verif/bilinear_rgba_interpolator_core_tb.sv
